// ----- hw/rtl/rrc_pkg.sv -----
// shared types, constants and the 5-to-8 bit expansion table of the row converter
package rrc_pkg;

  localparam int MAX_WIDTH_DEF = 4096;

  localparam int PIXEL_W = 24;
  localparam int ROW_W   = 13;
  localparam int CFG_W   = 13;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);

  // register indexes on the configuration port
  localparam logic CFG_IDX_MODE  = 1'b0;
  localparam logic CFG_IDX_WIDTH = 1'b1;

  // conversion modes
  localparam logic MODE_888_TO_555 = 1'b0;
  localparam logic MODE_555_TO_888 = 1'b1;

  localparam logic [1:0] BYTES_555 = 2'd2;
  localparam logic [1:0] BYTES_888 = 2'd3;

  // c * 255 / 31, truncated
  localparam logic [7:0] EXPAND5_LUT [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

  // one classified pixel, as handed from the front to the back
  typedef struct packed {
    logic [PIXEL_W-1:0] data;
    logic [1:0]         bytes;
    logic [1:0]         pad;
    logic               row_end;
  } rrc_entry_t;

  // queue status seen by its neighbors
  typedef struct packed {
    logic full;
    logic empty;
  } rrc_fifo_stat_t;

endpackage

// ----- hw/rtl/rrc_front.sv -----
// front end: configuration registers, column counter and pixel conversion
module rrc_front #(
  parameter int MAX_WIDTH = rrc_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [rrc_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        push,
  input  logic [rrc_pkg::PIXEL_W-1:0] in_pixel_in,
  input  rrc_pkg::rrc_fifo_stat_t     fifo_stat,
  output logic                        fifo_wr,
  output rrc_pkg::rrc_entry_t         fifo_wdata
);

  localparam int CNT_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW    = $clog2(MAX_WIDTH + 1);

  logic                      mode_r;
  logic [rrc_pkg::ROW_W-1:0] width_r;
  logic [CNT_W-1:0]          col_r;
  logic [CNT_W-1:0]          col_nxt;
  logic [EW-1:0]             eff_w;
  logic [1:0]                eff_lo;
  logic                      row_done;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= rrc_pkg::MODE_888_TO_555;
      width_r <= rrc_pkg::ROW_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        rrc_pkg::CFG_IDX_MODE:  mode_r  <= cfg_wdata[0];
        rrc_pkg::CFG_IDX_WIDTH: width_r <= cfg_wdata[rrc_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  // zero width acts as one, oversize widths saturate
  always_comb begin
    if (width_r == '0) begin
      eff_w = EW'(1);
    end else if (32'(width_r) > MAX_WIDTH) begin
      eff_w = EW'(MAX_WIDTH);
    end else begin
      eff_w = EW'(width_r);
    end
  end

  assign eff_lo   = 2'(eff_w);
  assign row_done = (32'(col_r) + 32'd1) >= 32'(eff_w);
  assign fifo_wr  = push && !fifo_stat.full;
  assign col_nxt  = row_done ? '0 : col_r + CNT_W'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
    end else if (fifo_wr) begin
      col_r <= col_nxt;
    end
  end

  always_comb begin
    fifo_wdata.row_end = row_done;
    if (mode_r == rrc_pkg::MODE_555_TO_888) begin
      fifo_wdata.data  = {rrc_pkg::EXPAND5_LUT[in_pixel_in[14:10]],
                          rrc_pkg::EXPAND5_LUT[in_pixel_in[9:5]],
                          rrc_pkg::EXPAND5_LUT[in_pixel_in[4:0]]};
      fifo_wdata.bytes = rrc_pkg::BYTES_888;
      // 3 bytes per pixel: pad is width mod 4
      fifo_wdata.pad   = row_done ? eff_lo : 2'd0;
    end else begin
      fifo_wdata.data  = {8'h00, 1'b0, in_pixel_in[23:19], in_pixel_in[15:11],
                          in_pixel_in[7:3]};
      fifo_wdata.bytes = rrc_pkg::BYTES_555;
      // 2 bytes per pixel: odd widths need two bytes
      fifo_wdata.pad   = row_done ? {eff_lo[0], 1'b0} : 2'd0;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    fifo_wr && !row_done |=> col_r == $past(col_r) + CNT_W'(1))
    else $error("column counter did not advance");

  assert property (@(posedge clk) disable iff (!rst_n)
    fifo_wr && row_done |=> col_r == '0)
    else $error("column counter not cleared at row end");

  assert property (@(posedge clk) disable iff (!rst_n)
    fifo_wdata.pad != 2'd0 |-> fifo_wdata.row_end)
    else $error("padding requested mid-row");

endmodule

// ----- hw/rtl/rrc_fifo.sv -----
// short queue of classified pixels between front and back
module rrc_fifo (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    wr_en,
  input  rrc_pkg::rrc_entry_t     wr_data,
  input  logic                    rd_en,
  output rrc_pkg::rrc_entry_t     rd_data,
  output rrc_pkg::rrc_fifo_stat_t stat
);

  localparam int PW = rrc_pkg::FIFO_PTR_W;

  rrc_pkg::rrc_entry_t mem_r [rrc_pkg::FIFO_DEPTH];
  logic [PW-1:0]       wr_ptr_r;
  logic [PW-1:0]       rd_ptr_r;
  logic [PW:0]         cnt_r;
  logic [PW:0]         cnt_nxt;

  assign stat.full  = cnt_r == (PW+1)'(rrc_pkg::FIFO_DEPTH);
  assign stat.empty = cnt_r == '0;
  assign rd_data    = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (wr_en && !rd_en) begin
      cnt_nxt = cnt_r + (PW+1)'(1);
    end else if (rd_en && !wr_en) begin
      cnt_nxt = cnt_r - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (wr_en) begin
        wr_ptr_r <= wr_ptr_r + PW'(1);
      end
      if (rd_en) begin
        rd_ptr_r <= rd_ptr_r + PW'(1);
      end
      cnt_r <= cnt_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) !(wr_en && stat.full))
    else $error("queue overflow");

  assert property (@(posedge clk) disable iff (!rst_n) !(rd_en && stat.empty))
    else $error("queue underflow");

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == (PW+1)'(PW'(wr_ptr_r - rd_ptr_r)) || stat.full)
    else $error("queue count disagrees with pointers");

endmodule

// ----- hw/rtl/rrc_back.sv -----
// back end: output register that plays out a pixel and its row padding
module rrc_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rrc_pkg::rrc_fifo_stat_t     fifo_stat,
  input  rrc_pkg::rrc_entry_t         fifo_rdata,
  output logic                        fifo_rd,
  input  logic                        pop,
  output logic                        empty,
  output logic [rrc_pkg::PIXEL_W-1:0] out_data_out,
  output logic [1:0]                  out_byte_count,
  output logic                        out_is_padding,
  output logic                        out_row_end,
  output logic                        out_last
);

  rrc_pkg::rrc_entry_t cur_r;
  logic                valid_r;
  logic                pad_phase_r;
  logic                take;
  logic                to_pad;
  logic                load;

  assign take   = valid_r && pop;
  assign to_pad = take && !pad_phase_r && (cur_r.pad != 2'd0);
  // refill once the current entry is gone or about to go
  assign load    = !valid_r || (take && !to_pad);
  assign fifo_rd = load && !fifo_stat.empty;

  always_ff @(posedge clk) begin
    if (fifo_rd) begin
      cur_r <= fifo_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r     <= 1'b0;
      pad_phase_r <= 1'b0;
    end else if (to_pad) begin
      pad_phase_r <= 1'b1;
    end else if (load) begin
      valid_r     <= !fifo_stat.empty;
      pad_phase_r <= 1'b0;
    end
  end

  always_comb begin
    empty = !valid_r;
    if (pad_phase_r) begin
      out_data_out   = '0;
      out_byte_count = cur_r.pad;
      out_is_padding = 1'b1;
      out_row_end    = 1'b1;
      out_last       = 1'b1;
    end else begin
      out_data_out   = cur_r.data;
      out_byte_count = cur_r.bytes;
      out_is_padding = 1'b0;
      out_row_end    = cur_r.row_end && (cur_r.pad == 2'd0);
      out_last       = cur_r.pad == 2'd0;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    pad_phase_r |-> valid_r && cur_r.pad != 2'd0)
    else $error("padding phase without pending padding");

  assert property (@(posedge clk) disable iff (!rst_n)
    to_pad |=> valid_r && pad_phase_r && $stable(cur_r))
    else $error("padding transfer lost after its pixel");

  assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !pop |=> valid_r && $stable(cur_r) && $stable(pad_phase_r))
    else $error("waiting result changed before transfer");

endmodule

// ----- hw/rtl/rgb888_rgb555_row_converter_unit.sv -----
// top level of the rgb888 / rgb555 row converter
//
//   channel   ports                              handshake
//   input     in_pixel_in                        push / full
//   result    out_data_out .. out_last           pop / empty
//   config    cfg_index, cfg_wdata               cfg_we, no wait
//
// one pixel is taken per cycle; the front converts it and counts columns in
// the cycle of its transfer, the back plays out one result per cycle from its
// output register, two results for a row's last pixel when padding is due.
// a four-entry queue sits between them, so a padding result costs one result
// slot and the input stalls only when that queue is full.
// synchronous active-low reset clears the counter, queue and output register.
module rgb888_rgb555_row_converter_unit #(
  parameter int MAX_WIDTH = rrc_pkg::MAX_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [rrc_pkg::CFG_W-1:0]   cfg_wdata,
  input  logic                        push,
  output logic                        full,
  input  logic [rrc_pkg::PIXEL_W-1:0] in_pixel_in,
  input  logic                        pop,
  output logic                        empty,
  output logic [rrc_pkg::PIXEL_W-1:0] out_data_out,
  output logic [1:0]                  out_byte_count,
  output logic                        out_is_padding,
  output logic                        out_row_end,
  output logic                        out_last
);

  rrc_pkg::rrc_fifo_stat_t fifo_stat;
  rrc_pkg::rrc_entry_t     fifo_wdata;
  rrc_pkg::rrc_entry_t     fifo_rdata;
  logic                    fifo_wr;
  logic                    fifo_rd;

  assign full = fifo_stat.full;

  rrc_front #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .push        (push),
    .in_pixel_in (in_pixel_in),
    .fifo_stat   (fifo_stat),
    .fifo_wr     (fifo_wr),
    .fifo_wdata  (fifo_wdata)
  );

  rrc_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fifo_wr),
    .wr_data (fifo_wdata),
    .rd_en   (fifo_rd),
    .rd_data (fifo_rdata),
    .stat    (fifo_stat)
  );

  rrc_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .fifo_stat      (fifo_stat),
    .fifo_rdata     (fifo_rdata),
    .fifo_rd        (fifo_rd),
    .pop            (pop),
    .empty          (empty),
    .out_data_out   (out_data_out),
    .out_byte_count (out_byte_count),
    .out_is_padding (out_is_padding),
    .out_row_end    (out_row_end),
    .out_last       (out_last)
  );

endmodule
